// ----- src/vpn_pkg.sv -----
// shared constants and types of the voxel probability normaliser
`timescale 1ns / 1ps
`default_nettype none
package vpn_pkg;
    localparam int MAX_TISSUES_DEF = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int NUM_SLOTS       = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 4;
    localparam logic [CFG_IDX_W-1:0] REG_TISSUE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_MODE      = 2'd1;

    typedef struct packed {
        logic valid;
        logic bgm;
        logic zero;
    } t_ctrl;
endpackage
`default_nettype wire

// ----- src/vpn_div_lane.sv -----
// one pipelined restoring divider lane with signed saturation
`timescale 1ns / 1ps
`default_nettype none
module vpn_div_lane
    import vpn_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire signed [SAMPLE_BITS-1:0]  i_value,
    input  wire signed [SAMPLE_BITS+3:0]  i_sum,
    output logic signed [SAMPLE_BITS-1:0] o_quot
);
    localparam int SB   = SAMPLE_BITS;
    localparam int FRAC = SB - 2;
    localparam int SW   = SB + 4;
    localparam int RW   = SB + FRAC;
    localparam int CW   = SW + SB;

    logic [RW-1:0] r_rem [0:SB];
    logic [SB-1:0] r_q   [0:SB];
    logic [SW-1:0] r_div [0:SB];
    logic          r_neg [0:SB];
    logic          r_ovf [0:SB];

    logic [SB-1:0] mag;
    logic          ovf;

    assign mag = i_value[SB-1] ? SB'(-i_value) : SB'(i_value);
    assign ovf = {2'b00, mag} >= {2'b00, SB'(i_sum), 2'b00} || (SW > SB &&
                 (i_sum[SW-1:SB] != '0));

    always_ff @(posedge i_clk) begin
        r_rem[0] <= RW'({mag, FRAC'(0)});
        r_q[0]   <= '0;
        r_div[0] <= SW'(i_sum);
        r_neg[0] <= i_value[SB-1];
        r_ovf[0] <= ovf && !(i_sum[SW-1:SB] != '0);
    end

    for (genvar k = 0; k < SB; k++) begin : g_step
        localparam int BI = SB - 1 - k;
        logic [CW-1:0] shifted;
        logic [CW-1:0] rem_ext;
        logic          take;
        assign shifted = CW'(r_div[k]) << BI;
        assign rem_ext = CW'(r_rem[k]);
        assign take    = rem_ext >= shifted;
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= take ? RW'(rem_ext - shifted) : r_rem[k];
            r_q[k+1]   <= r_q[k] | (SB'(take) << BI);
            r_div[k+1] <= r_div[k];
            r_neg[k+1] <= r_neg[k];
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    localparam logic [SB-1:0] HALF = SB'(1) << (SB - 1);

    always_comb begin
        if (r_neg[SB]) begin
            if (r_ovf[SB] || r_q[SB] > HALF) o_quot = signed'(HALF);
            else o_quot = signed'(SB'(-r_q[SB]));
        end else begin
            if (r_ovf[SB] || r_q[SB][SB-1]) o_quot = signed'(HALF - SB'(1));
            else o_quot = signed'(r_q[SB]);
        end
    end
endmodule
`default_nettype wire

// ----- src/voxel_probability_normalizer_unit.sv -----
// voxel probability normaliser: clamp, sum and divide each slot by the sum
// a request passes the clamp and sum stages, the divider lanes and the output register to done
// throughput: one request per cycle, busy never rises
// the divider bank resolves one quotient bit per stage, setting the latency
// synchronous active-low reset clears valid bits and config to 8 tissues, plain mode
// the receiver cannot stall, results are strobed for one cycle
`timescale 1ns / 1ps
`default_nettype none
module voxel_probability_normalizer_unit
    import vpn_pkg::*;
#(
    parameter int MAX_TISSUES = MAX_TISSUES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    output logic                         o_busy,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [CFG_DATA_W-1:0]         i_cfg_data,
    input  wire signed [SAMPLE_BITS-1:0] i_prob_0,
    input  wire signed [SAMPLE_BITS-1:0] i_prob_1,
    input  wire signed [SAMPLE_BITS-1:0] i_prob_2,
    input  wire signed [SAMPLE_BITS-1:0] i_prob_3,
    input  wire signed [SAMPLE_BITS-1:0] i_prob_4,
    input  wire signed [SAMPLE_BITS-1:0] i_prob_5,
    input  wire signed [SAMPLE_BITS-1:0] i_prob_6,
    input  wire signed [SAMPLE_BITS-1:0] i_prob_7,
    input  wire signed [SAMPLE_BITS-1:0] i_background_prob,
    output logic                         o_done,
    output logic signed [SAMPLE_BITS-1:0] o_norm_0,
    output logic signed [SAMPLE_BITS-1:0] o_norm_1,
    output logic signed [SAMPLE_BITS-1:0] o_norm_2,
    output logic signed [SAMPLE_BITS-1:0] o_norm_3,
    output logic signed [SAMPLE_BITS-1:0] o_norm_4,
    output logic signed [SAMPLE_BITS-1:0] o_norm_5,
    output logic signed [SAMPLE_BITS-1:0] o_norm_6,
    output logic signed [SAMPLE_BITS-1:0] o_norm_7,
    output logic signed [SAMPLE_BITS-1:0] o_norm_background,
    output logic                         o_zero_sum
);
    localparam int SB    = SAMPLE_BITS;
    localparam int FRAC  = SB - 2;
    localparam int SW    = SB + 4;
    localparam int LANES = NUM_SLOTS + 1;
    localparam int LAT   = SB + 4;
    localparam logic [3:0] MAXN = 4'(MAX_TISSUES);
    localparam logic signed [SB-1:0] ONE = SB'(1) << FRAC;

    logic [3:0] r_tissue_count;
    logic       r_bg_mode;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tissue_count <= 4'd8;
            r_bg_mode      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TISSUE_COUNT: r_tissue_count <= i_cfg_data[3:0];
                REG_BG_MODE:      r_bg_mode      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic signed [SB-1:0] raw [0:LANES-1];
    assign raw[0] = i_prob_0;
    assign raw[1] = i_prob_1;
    assign raw[2] = i_prob_2;
    assign raw[3] = i_prob_3;
    assign raw[4] = i_prob_4;
    assign raw[5] = i_prob_5;
    assign raw[6] = i_prob_6;
    assign raw[7] = i_prob_7;
    assign raw[8] = i_background_prob;

    logic [3:0] n_eff;
    assign n_eff = (r_tissue_count == 4'd0) ? 4'd1 :
                   (r_tissue_count > MAXN) ? MAXN : r_tissue_count;

    // stage 1: slot masking and clamping
    logic signed [SB-1:0] r_v1 [0:LANES-1];
    logic signed [SB-1:0] r_v2 [0:LANES-1];
    logic signed [SW-1:0] r_sum2;
    t_ctrl                r_c1, r_c2;
    t_ctrl                r_cd [0:SB];

    for (genvar j = 0; j < LANES; j++) begin : g_in
        logic signed [SB-1:0] n_v;
        always_comb begin
            if (j == NUM_SLOTS) begin
                n_v = r_bg_mode ? raw[j] : '0;
            end else if (4'(j) >= n_eff) begin
                n_v = '0;
            end else if (!r_bg_mode && 4'(j) < n_eff - 4'd1 && raw[j][SB-1]) begin
                n_v = '0;
            end else begin
                n_v = raw[j];
            end
        end
        always_ff @(posedge i_clk) begin
            r_v1[j] <= n_v;
            r_v2[j] <= r_v1[j];
        end
    end

    // stage 2: sum over all slots
    logic signed [SW-1:0] n_sum;
    always_comb begin
        n_sum = '0;
        for (int j = 0; j < LANES; j++) n_sum = n_sum + SW'(r_v1[j]);
    end

    always_ff @(posedge i_clk) begin
        r_sum2 <= n_sum;
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
        end else begin
            r_c1 <= '{valid: i_start && !o_busy, bgm: r_bg_mode, zero: 1'b0};
            r_c2 <= r_c1;
        end
    end

    // control delay line matched to the divider lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SB; k++) r_cd[k] <= '0;
        end else begin
            r_cd[0] <= '{valid: r_c2.valid, bgm: r_c2.bgm, zero: r_sum2 <= 0};
            for (int k = 0; k < SB; k++) r_cd[k+1] <= r_cd[k];
        end
    end

    logic signed [SB-1:0] quot [0:LANES-1];
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        vpn_div_lane #(.SAMPLE_BITS(SB)) u_lane (
            .i_clk  (i_clk),
            .i_value(r_v2[j]),
            .i_sum  (r_sum2),
            .o_quot (quot[j])
        );
    end

    // output register
    logic signed [SB-1:0] r_out [0:LANES-1];
    logic                 r_done, r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= r_cd[SB].valid;
        r_zero <= r_cd[SB].zero;
        for (int j = 0; j < LANES; j++) begin
            if (!r_cd[SB].zero) r_out[j] <= quot[j];
            else if (j == NUM_SLOTS && r_cd[SB].bgm) r_out[j] <= ONE;
            else r_out[j] <= '0;
        end
    end

    assign o_done            = r_done;
    assign o_zero_sum        = r_zero;
    assign o_norm_0          = r_out[0];
    assign o_norm_1          = r_out[1];
    assign o_norm_2          = r_out[2];
    assign o_norm_3          = r_out[3];
    assign o_norm_4          = r_out[4];
    assign o_norm_5          = r_out[5];
    assign o_norm_6          = r_out[6];
    assign o_norm_7          = r_out[7];
    assign o_norm_background = r_out[NUM_SLOTS];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(LAT) o_done)
        else $error("request did not complete at fixed latency");
    a_zero_tissue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_zero_sum) |-> (o_norm_0 == 0 && o_norm_7 == 0))
        else $error("zero sum result carries tissue values");
    a_zero_bg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_zero_sum) |-> (o_norm_background == 0 || o_norm_background == ONE))
        else $error("zero sum background default wrong");
endmodule
`default_nettype wire

// ----- dv/tb_voxel_probability_normalizer_unit.sv -----
// testbench of the voxel probability normaliser: random and corner voxels checked against a predictor
`timescale 1ns / 1ps
module tb_voxel_probability_normalizer_unit;
    import vpn_pkg::*;

    localparam int SB = 16;
    localparam int LAT = SB + 4;

    typedef struct {
        logic signed [SB-1:0] p [8];
        logic signed [SB-1:0] bg;
    } t_voxel;

    typedef struct {
        logic signed [SB-1:0] n [8];
        logic signed [SB-1:0] nbg;
        logic                 zs;
    } t_norm;

    logic i_clk, i_rst_n, i_start, i_cfg_valid;
    logic o_busy, o_cfg_ready, o_done, o_zero_sum;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic signed [SB-1:0] i_prob [8];
    logic signed [SB-1:0] i_background_prob;
    logic signed [SB-1:0] o_norm [8];
    logic signed [SB-1:0] o_norm_background;

    voxel_probability_normalizer_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_prob_0(i_prob[0]), .i_prob_1(i_prob[1]), .i_prob_2(i_prob[2]),
        .i_prob_3(i_prob[3]), .i_prob_4(i_prob[4]), .i_prob_5(i_prob[5]),
        .i_prob_6(i_prob[6]), .i_prob_7(i_prob[7]),
        .i_background_prob(i_background_prob), .o_done(o_done),
        .o_norm_0(o_norm[0]), .o_norm_1(o_norm[1]), .o_norm_2(o_norm[2]),
        .o_norm_3(o_norm[3]), .o_norm_4(o_norm[4]), .o_norm_5(o_norm[5]),
        .o_norm_6(o_norm[6]), .o_norm_7(o_norm[7]),
        .o_norm_background(o_norm_background), .o_zero_sum(o_zero_sum)
    );

    t_voxel voxel_q [$];
    t_norm  norm_q [$];
    int     errors = 0;
    int     gap = 0;
    bit     feed_on = 0;
    logic [3:0] m_tissues = 4'd8;
    logic       m_bgm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [SB-1:0] quot_sat(longint val, longint sum);
        longint q;
        q = (val * 16384) / sum;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[SB-1:0];
    endfunction

    function automatic t_norm normalise(t_voxel vx);
        t_norm r;
        longint v [8];
        longint sum;
        int n;
        sum = 0;
        n = (m_tissues < 1) ? 1 : ((m_tissues > 8) ? 8 : int'(m_tissues));
        foreach (r.n[j]) r.n[j] = '0;
        r.nbg = '0;
        r.zs = 1'b0;
        for (int j = 0; j < n; j++) begin
            v[j] = vx.p[j];
            if (!m_bgm && j < n - 1 && v[j] < 0) v[j] = 0;
            sum += v[j];
        end
        if (m_bgm) sum += longint'(vx.bg);
        if (sum > 0) begin
            for (int j = 0; j < n; j++) r.n[j] = quot_sat(v[j], sum);
            if (m_bgm) r.nbg = quot_sat(vx.bg, sum);
        end else begin
            r.zs = 1'b1;
            if (m_bgm) r.nbg = 16'sd16384;
        end
        return r;
    endfunction

    task automatic report(string what, int exp_v, int got_v);
        errors++;
        $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_v, got_v);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n || !feed_on) begin
            i_start <= 1'b0;
        end else if (i_start && !o_busy) begin
            norm_q = {norm_q, normalise(voxel_q.pop_front())};
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap == 0 && voxel_q.size() > 0) begin
                foreach (i_prob[j]) i_prob[j] <= voxel_q[0].p[j];
                i_background_prob <= voxel_q[0].bg;
            end else begin
                i_start <= 1'b0;
            end
        end else if (!i_start && voxel_q.size() > 0) begin
            if (gap > 0) begin
                gap--;
            end else begin
                foreach (i_prob[j]) i_prob[j] <= voxel_q[0].p[j];
                i_background_prob <= voxel_q[0].bg;
                i_start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_norm e;
        if (i_rst_n && o_done) begin
            if (norm_q.size() == 0) begin
                report("unexpected result", 0, 1);
            end else begin
                e = norm_q.pop_front();
                for (int j = 0; j < 8; j++)
                    if (o_norm[j] !== e.n[j]) report($sformatf("norm_%0d", j), e.n[j], o_norm[j]);
                if (o_norm_background !== e.nbg)
                    report("norm_background", e.nbg, o_norm_background);
                if (o_zero_sum !== e.zs) report("zero_sum", e.zs, o_zero_sum);
            end
        end
    end

    function automatic logic signed [SB-1:0] rnd_prob();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return SB'(int'($urandom_range(0, 16)) - 8);
            4, 5: return -$signed({1'b0, 15'($urandom_range(0, 3000))});
            default: return SB'($urandom_range(0, 16384));
        endcase
    endfunction

    function automatic t_voxel rnd_voxel();
        t_voxel vx;
        foreach (vx.p[j]) vx.p[j] = rnd_prob();
        vx.bg = rnd_prob();
        if ($urandom_range(0, 7) == 0) begin
            foreach (vx.p[j]) vx.p[j] = SB'($urandom);
            vx.bg = SB'($urandom);
        end
        return vx;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_TISSUE_COUNT) m_tissues = val;
        else if (idx == REG_BG_MODE) m_bgm = val[0];
    endtask

    task automatic run_phase(int count, bit directed);
        t_voxel vx;
        if (directed) begin
            vx.bg = 16'sd16384;
            foreach (vx.p[j]) vx.p[j] = '0;
            voxel_q = {voxel_q, vx};
            foreach (vx.p[j]) vx.p[j] = 16'sh7fff;
            vx.bg = 16'sh8000;
            voxel_q = {voxel_q, vx};
            foreach (vx.p[j]) vx.p[j] = 16'sh8000;
            vx.bg = 16'sh7fff;
            voxel_q = {voxel_q, vx};
            foreach (vx.p[j]) vx.p[j] = 16'sd2048;
            vx.p[1] = -16'sd2000;
            vx.p[7] = -16'sd3000;
            vx.bg = -16'sd1000;
            voxel_q = {voxel_q, vx};
            foreach (vx.p[j]) vx.p[j] = -16'sd1;
            vx.p[0] = 16'sd1;
            voxel_q = {voxel_q, vx};
        end
        repeat (count) voxel_q = {voxel_q, rnd_voxel()};
        feed_on = 1;
        wait (voxel_q.size() == 0 && !i_start);
        wait (norm_q.size() == 0);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        foreach (i_prob[j]) i_prob[j] = '0;
        i_background_prob = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(40, 1);
        write_reg(REG_BG_MODE, 4'd1);
        run_phase(60, 1);
        write_reg(REG_TISSUE_COUNT, 4'd1);
        run_phase(40, 1);
        write_reg(REG_BG_MODE, 4'd0);
        run_phase(40, 1);
        write_reg(REG_TISSUE_COUNT, 4'd0);
        run_phase(20, 0);
        write_reg(REG_TISSUE_COUNT, 4'd15);
        write_reg(REG_BG_MODE, 4'd1);
        run_phase(30, 0);
        write_reg(REG_TISSUE_COUNT, 4'd9);
        run_phase(10, 0);
        for (int k = 0; k < 8; k++) begin
            write_reg(REG_TISSUE_COUNT, 4'($urandom_range(1, 8)));
            write_reg(REG_BG_MODE, 4'($urandom_range(0, 1)));
            run_phase(30, 0);
        end
        if (errors == 0) begin
            $display("** voxel_probability_normalizer_unit: PASSED **");
        end else begin
            $display("** voxel_probability_normalizer_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** voxel_probability_normalizer_unit: FAILED **");
        $finish;
    end
endmodule

// ----- sim.f -----
src/vpn_pkg.sv
src/vpn_div_lane.sv
src/voxel_probability_normalizer_unit.sv
dv/tb_voxel_probability_normalizer_unit.sv
